@@ hw/rtl/ctl_pkg.sv @@
// Package of types, constants and helper functions for the C token lexer.
package ctl_pkg;

  localparam int OFFSET_WIDTH = 32;
  localparam int MAX_KEYWORD_LENGTH = 13;
  localparam int LENGTH_WIDTH = 16;
  localparam int KW_COUNT = 24;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW = 2;

  localparam logic [4:0] K_PUNCT  = 5'd0;
  localparam logic [4:0] K_NUM    = 5'd1;
  localparam logic [4:0] K_IDENT  = 5'd2;
  localparam logic [4:0] K_STRCH  = 5'd3;
  localparam logic [4:0] K_BRACE  = 5'd4;
  localparam logic [4:0] K_TYPE   = 5'd5;
  localparam logic [4:0] K_EOF    = 5'd23;
  localparam logic [4:0] K_ERR    = 5'd24;
  localparam logic [4:0] K_DEFINE = 5'd25;

  // Reported lengths of single-byte tokens, two-byte punctuators and define notices.
  localparam logic [LENGTH_WIDTH-1:0] LEN_ONE    = LENGTH_WIDTH'(1);
  localparam logic [LENGTH_WIDTH-1:0] LEN_PAIR   = LENGTH_WIDTH'(2);
  localparam logic [LENGTH_WIDTH-1:0] LEN_DEFINE = LENGTH_WIDTH'(7);

  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  // Largest accumulator that can still take a digit d: (VAL_MAX - d) / 10.
  localparam logic [63:0] SAT_LIM_LO = 64'd922337203685477580;

  typedef logic [MAX_KEYWORD_LENGTH*8-1:0] word_t;

  typedef struct packed {
    logic [4:0]              kind;
    logic [4:0]              kidx;
    logic [OFFSET_WIDTH-1:0] start;
    logic [LENGTH_WIDTH-1:0] len;
    logic [63:0]             value;
    logic                    last;
  } token_t;

  // Keyword text packed byte 0 in the low bits.
  function automatic word_t kw_text(input int i);
    string s;
    word_t w;
    case (i)
      0: s = "void";      1: s = "_Bool";    2: s = "char";     3: s = "int";
      4: s = "long";      5: s = "struct";   6: s = "enum";     7: s = "if";
      8: s = "else";      9: s = "switch";   10: s = "case";    11: s = "default";
      12: s = "for";      13: s = "do";      14: s = "while";   15: s = "break";
      16: s = "continue"; 17: s = "sizeof";  18: s = {"_Align", "of"};
      19: s = "typedef";  20: s = "return";  21: s = "extern";  22: s = "const";
      default: s = {"_Thread", "_local"};
    endcase
    w = '0;
    for (int k = 0; k < MAX_KEYWORD_LENGTH; k++) begin
      if (k < s.len()) w[k*8 +: 8] = s[k];
    end
    return w;
  endfunction

  function automatic int kw_len(input int i);
    case (i)
      3, 12: return 3;
      7, 13: return 2;
      1, 14, 15, 22: return 5;
      5, 9, 17, 20, 21: return 6;
      11, 19: return 7;
      16, 18: return 8;
      23: return 13;
      default: return 4;
    endcase
  endfunction

  function automatic logic ident_char(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
           (c >= "0" && c <= "9") || c == "_";
  endfunction

endpackage

@@ hw/rtl/ctl_if.sv @@
// Valid/ready channel interfaces for the lexer's input and result words.
interface ctl_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;
  modport source(output valid, text_byte, end_of_text, input ready);
  modport sink(input valid, text_byte, end_of_text, output ready);
endinterface

interface ctl_out_if;
  logic        valid;
  logic        ready;
  logic [4:0]  token_kind;
  logic [4:0]  keyword_index;
  logic [31:0] start_offset;
  logic [15:0] token_length;
  logic [63:0] token_value;
  logic        last_result;
  modport source(output valid, token_kind, keyword_index, start_offset, token_length,
                 token_value, last_result, input ready);
  modport sink(input valid, token_kind, keyword_index, start_offset, token_length,
               token_value, last_result, output ready);
endinterface

@@ hw/rtl/c_token_lexer.sv @@
// Top level of the C token lexer: front end, token queue and output channel.
// A token is written into the token queue as the word that causes it is taken.
// Throughput: one text word a cycle while the four-entry token queue has room for
// three tokens; the queue drains one token a cycle while out_ch is ready.
// Reset: synchronous rst returns the lexer to idle at offset zero and empties the queue.
module c_token_lexer (
  input  logic     clk,
  input  logic     rst,
  ctl_in_if.sink   in_ch,
  ctl_out_if.source out_ch
);
  import ctl_pkg::*;

  logic       space_ok;
  logic [1:0] tok_count;
  token_t     tok0, tok1, tok2, head;

  ctl_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_ch.valid), .in_ready(in_ch.ready),
    .in_byte(in_ch.text_byte), .in_end(in_ch.end_of_text),
    .space_ok(space_ok), .tok_count(tok_count),
    .tok0(tok0), .tok1(tok1), .tok2(tok2)
  );

  ctl_queue u_queue (
    .clk(clk), .rst(rst),
    .push_count(tok_count), .push0(tok0), .push1(tok1), .push2(tok2),
    .space_ok(space_ok),
    .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_tok(head)
  );

  assign out_ch.token_kind    = head.kind;
  assign out_ch.keyword_index = head.kidx;
  assign out_ch.start_offset  = head.start;
  assign out_ch.token_length  = head.len;
  assign out_ch.token_value   = head.value;
  assign out_ch.last_result   = head.last;

  // A taken word never produces tokens without queue room.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    (tok_count != 2'd0) |-> space_ok) else $error("tokens pushed without room");

  // Ready follows queue room only.
  a_ready_room: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready == space_ok) else $error("ready out of step with queue room");

  // In a burst of two tokens, only the second carries last_result.
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    (tok_count == 2'd2) |-> (!tok0.last && tok1.last)) else $error("bad last mark");

endmodule

@@ hw/rtl/ctl_front.sv @@
// Front end: one text word a cycle while the queue has room, lexed into up to three tokens.
module ctl_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      in_byte,
  input  logic            in_end,
  input  logic            space_ok,
  output logic [1:0]      tok_count,
  output ctl_pkg::token_t tok0,
  output ctl_pkg::token_t tok1,
  output ctl_pkg::token_t tok2
);
  import ctl_pkg::*;

  typedef enum logic [3:0] {
    PH_IDLE, PH_SYM, PH_BSL, PH_SKIP, PH_BLK1, PH_BLK, PH_CH, PH_CHESC,
    PH_CHEND, PH_NUM, PH_WORD, PH_HASH, PH_DWORD, PH_STR
  } phase_t;

  phase_t                  lex_phase, lex_phase_next;
  logic [7:0]              pending_byte, pending_byte_next;
  logic [7:0]              previous_byte, previous_byte_next;
  logic [OFFSET_WIDTH-1:0] byte_position;
  logic [OFFSET_WIDTH-1:0] token_start, token_start_next;
  logic [LENGTH_WIDTH-1:0] word_length, word_length_next;
  word_t                   word_buffer, word_buffer_next;
  logic [63:0]             number_accumulator, number_accumulator_next;
  logic                    halted, halted_next;
  logic                    sat_over;
  logic [63:0]             acc_mul;

  token_t     t [3];
  logic [1:0] n;

  logic                    kw_hit;
  logic [4:0]              kw_idx;
  logic [OFFSET_WIDTH-1:0] pos;
  logic                    fire;

  assign pos      = byte_position;
  assign in_ready = space_ok;
  assign fire     = in_valid && in_ready && !halted;

  // Multiply by ten, add the new digit, and check saturation on the accumulator.
  always_comb begin
    logic [63:0] d;
    d = 64'(in_byte - 8'h30);
    acc_mul  = (number_accumulator << 3) + (number_accumulator << 1) + d;
    sat_over = (number_accumulator > SAT_LIM_LO) ||
               (number_accumulator == SAT_LIM_LO && d > 64'd7);
  end

  // Keyword match over the buffered word against the parallel table.
  always_comb begin
    kw_hit = 1'b0;
    kw_idx = '0;
    for (int i = KW_COUNT - 1; i >= 0; i--) begin
      word_t m;
      m = '0;
      for (int k = 0; k < MAX_KEYWORD_LENGTH; k++) begin
        if (k < kw_len(i)) m[k*8 +: 8] = 8'hFF;
      end
      if (word_length == LENGTH_WIDTH'(kw_len(i)) &&
          ((word_buffer ^ kw_text(i)) & m) == '0) begin
        kw_hit = 1'b1;
        kw_idx = 5'(i);
      end
    end
  end

  // Token builder: makes one token with last_result clear.
  function automatic token_t mk(input logic [4:0] kd, input logic [4:0] ki,
                                input logic [OFFSET_WIDTH-1:0] st,
                                input logic [LENGTH_WIDTH-1:0] ln, input logic [63:0] v);
    token_t r;
    r.kind = kd; r.kidx = ki; r.start = st; r.len = ln; r.value = v; r.last = 1'b0;
    return r;
  endfunction

  // Lexer step for one word.
  always_comb begin
    logic       disp;
    logic       failf;
    logic [OFFSET_WIDTH-1:0] fpos;
    logic [7:0] b;
    logic [7:0] c;
    logic       wadd;
    logic [7:0] wbyte;
    logic       wstart;
    logic [63:0] v;
    word_t      nb;
    logic [LENGTH_WIDTH-1:0] nl;
    logic       dw_incl;
    b = in_byte;
    c = pending_byte;
    disp = 1'b0; failf = 1'b0; fpos = pos;
    wadd = 1'b0; wstart = 1'b0; wbyte = b;
    v = '0;
    lex_phase_next          = lex_phase;
    pending_byte_next       = pending_byte;
    previous_byte_next      = previous_byte;
    token_start_next        = token_start;
    word_length_next        = word_length;
    word_buffer_next        = word_buffer;
    number_accumulator_next = number_accumulator;
    halted_next             = halted;
    n = 2'd0;
    t[0] = mk('0, '0, '0, '0, '0); t[1] = t[0]; t[2] = t[0];
    dw_incl = 1'b0;

    if (fire && in_end) begin
      halted_next    = 1'b1;
      lex_phase_next = PH_IDLE;
      case (lex_phase)
        PH_SYM: begin
          if (c == "|") failf = 1'b1;
          else begin t[n] = mk(K_PUNCT, '0, token_start, LEN_ONE, '0); n = n + 2'd1; end
          fpos = token_start;
        end
        PH_BSL: begin failf = 1'b1; fpos = token_start; end
        PH_NUM: begin
          t[n] = mk(K_NUM, '0, token_start, LEN_ONE, number_accumulator); n = n + 2'd1;
        end
        PH_WORD: begin
          t[n] = kw_hit ? mk(kw_idx < 5'd7 ? K_TYPE : kw_idx - 5'd1, kw_idx, token_start,
                             word_length, '0)
                        : mk(K_IDENT, '0, token_start, word_length, '0);
          n = n + 2'd1;
        end
        PH_DWORD: begin
          t[n] = mk(K_IDENT, '0, token_start, word_length, '0); n = n + 2'd1;
        end
        PH_IDLE, PH_SKIP: ;
        default: failf = 1'b1;
      endcase
      if (!failf) begin t[n] = mk(K_EOF, '0, pos, LEN_ONE, '0); n = n + 2'd1; end
    end else if (fire) begin
      case (lex_phase)
        PH_SYM: begin
          if (c == "/" && b == "/") lex_phase_next = PH_SKIP;
          else if (c == "/" && b == "*") lex_phase_next = PH_BLK1;
          else if ((b == "=" && c inside {"<", "=", ">", "!", "+", "*", "-", "/"}) ||
                   (b == c && c inside {"<", ">", "&", "|", "+", "-"}) ||
                   (c == "-" && b == ">")) begin
            t[n] = mk(K_PUNCT, '0, token_start, LEN_PAIR, '0); n = n + 2'd1;
            lex_phase_next = PH_IDLE;
          end else if (c == "|") begin
            failf = 1'b1; fpos = token_start;
          end else begin
            t[n] = mk(K_PUNCT, '0, token_start, LEN_ONE, '0); n = n + 2'd1;
            disp = 1'b1;
          end
        end
        PH_BSL: begin
          if (b == "\\") begin
            t[n] = mk(K_IDENT, '0, token_start, LEN_ONE, '0); n = n + 2'd1;
            lex_phase_next = PH_IDLE;
          end else begin
            failf = 1'b1; fpos = token_start;
          end
        end
        PH_SKIP: if (b == 8'd10) lex_phase_next = PH_IDLE;
        PH_BLK1: begin previous_byte_next = b; lex_phase_next = PH_BLK; end
        PH_BLK: begin
          if (previous_byte == "*" && b == "/") lex_phase_next = PH_IDLE;
          else previous_byte_next = b;
        end
        PH_CH: begin
          if (b == "\\") lex_phase_next = PH_CHESC;
          else begin
            t[n] = mk(K_NUM, '0, pos, LEN_ONE, {{56{b[7]}}, b}); n = n + 2'd1;
            lex_phase_next = PH_CHEND;
          end
        end
        PH_CHESC: begin
          case (b)
            "0":  v = 64'd0;
            "n":  v = 64'd10;
            "t":  v = 64'd9;
            "\\": v = 64'd92;
            "'":  v = 64'd39;
            default: failf = 1'b1;
          endcase
          if (!failf) begin
            t[n] = mk(K_NUM, '0, pos, LEN_ONE, v); n = n + 2'd1;
            lex_phase_next = PH_CHEND;
          end
        end
        PH_CHEND: if (b == "'") lex_phase_next = PH_IDLE; else failf = 1'b1;
        PH_NUM: begin
          if (b >= "0" && b <= "9") begin
            number_accumulator_next = sat_over ? VAL_MAX : acc_mul;
          end else begin
            t[n] = mk(K_NUM, '0, token_start, LEN_ONE, number_accumulator); n = n + 2'd1;
            disp = 1'b1;
          end
        end
        PH_WORD: begin
          if (ident_char(b)) wadd = 1'b1;
          else begin
            t[n] = kw_hit ? mk(kw_idx < 5'd7 ? K_TYPE : kw_idx - 5'd1, kw_idx, token_start,
                               word_length, '0)
                          : mk(K_IDENT, '0, token_start, word_length, '0);
            n = n + 2'd1;
            disp = 1'b1;
          end
        end
        PH_HASH: begin
          if (ident_char(b)) begin
            wstart = 1'b1; lex_phase_next = PH_DWORD;
          end else begin
            lex_phase_next = PH_IDLE;
            if (b == "{" || b == "}") begin
              t[n] = mk(K_BRACE, '0, pos, LEN_ONE, '0); n = n + 2'd1;
            end else if (b == "\"") begin
              t[n] = mk(K_PUNCT, '0, pos, LEN_ONE, '0); n = n + 2'd1;
              previous_byte_next = "\""; lex_phase_next = PH_STR;
            end else if (b == "\\") begin
              token_start_next = pos; pending_byte_next = "\\"; lex_phase_next = PH_BSL;
            end else failf = 1'b1;
          end
        end
        PH_DWORD: begin
          if (ident_char(b)) begin
            wadd = 1'b1;
            dw_incl = 1'b1;
          end else begin
            t[n] = mk(K_IDENT, '0, token_start, word_length, '0); n = n + 2'd1;
            disp = 1'b1;
          end
        end
        PH_STR: begin
          if (b == "\"" && previous_byte != "\\") begin
            t[n] = mk(K_PUNCT, '0, pos, LEN_ONE, '0); n = n + 2'd1;
            lex_phase_next = PH_IDLE;
          end else begin
            t[n] = mk(K_STRCH, '0, pos, LEN_ONE, '0); n = n + 2'd1;
          end
          previous_byte_next = b;
        end
        default: disp = 1'b1;
      endcase

      // Dispatch of a byte from the idle state.
      if (disp) begin
        lex_phase_next = PH_IDLE;
        if (b == " " || b == 8'd9 || b == 8'd10) begin
        end else if (b == "'") lex_phase_next = PH_CH;
        else if (b >= "0" && b <= "9") begin
          token_start_next = pos;
          number_accumulator_next = 64'(b - 8'h30);
          lex_phase_next = PH_NUM;
        end else if (b inside {"<", "=", ">", "!", "+", "*", "-", "/", "&", "|"}) begin
          token_start_next = pos; pending_byte_next = b; lex_phase_next = PH_SYM;
        end else if (b inside {"%", "(", ")", ",", ";", ".", "[", "]", "?", ":"}) begin
          t[n] = mk(K_PUNCT, '0, pos, LEN_ONE, '0); n = n + 2'd1;
        end else if (ident_char(b)) begin
          wstart = 1'b1; lex_phase_next = PH_WORD;
        end else if (b == "#") begin
          token_start_next = pos; lex_phase_next = PH_HASH;
        end else if (b == "{" || b == "}") begin
          t[n] = mk(K_BRACE, '0, pos, LEN_ONE, '0); n = n + 2'd1;
        end else if (b == "\"") begin
          t[n] = mk(K_PUNCT, '0, pos, LEN_ONE, '0); n = n + 2'd1;
          previous_byte_next = "\""; lex_phase_next = PH_STR;
        end else if (b == "\\") begin
          token_start_next = pos; pending_byte_next = "\\"; lex_phase_next = PH_BSL;
        end else failf = 1'b1;
      end
    end

    // Word buffer update for a new or growing word.
    nb = word_buffer;
    nl = word_length;
    if (wstart) begin
      token_start_next = pos;
      nl = '0;
    end
    if (wstart || wadd) begin
      for (int k = 0; k < MAX_KEYWORD_LENGTH; k++) begin
        if (nl == LENGTH_WIDTH'(k)) nb[k*8 +: 8] = wbyte;
      end
      if (nl != {LENGTH_WIDTH{1'b1}}) nl = nl + 1'b1;
      word_buffer_next = nb;
      word_length_next = nl;
    end

    // Directive words are checked against include and define as they grow.
    if (dw_incl) begin
      if (nl == LENGTH_WIDTH'(7) && nb[55:0] == {"edulcni"}) lex_phase_next = PH_SKIP;
      else if (nl == LENGTH_WIDTH'(6) && nb[47:0] == {"enifed"}) begin
        lex_phase_next = PH_SKIP;
        t[n] = mk(K_DEFINE, '0, token_start - 1'b1, LEN_DEFINE, '0); n = n + 2'd1;
      end
    end

    if (failf) begin
      t[n] = mk(K_ERR, '0, fpos, LEN_ONE, '0); n = n + 2'd1;
      halted_next = 1'b1;
      lex_phase_next = PH_IDLE;
    end
    if (n != 2'd0) t[n - 2'd1].last = 1'b1;
  end

  assign tok_count = n;
  assign tok0 = t[0];
  assign tok1 = t[1];
  assign tok2 = t[2];

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      lex_phase          <= PH_IDLE;
      pending_byte       <= '0;
      previous_byte      <= '0;
      byte_position      <= '0;
      token_start        <= '0;
      word_length        <= '0;
      number_accumulator <= '0;
      halted             <= 1'b0;
    end else begin
      lex_phase          <= lex_phase_next;
      pending_byte       <= pending_byte_next;
      previous_byte      <= previous_byte_next;
      token_start        <= token_start_next;
      word_length        <= word_length_next;
      number_accumulator <= number_accumulator_next;
      halted             <= halted_next;
      if (fire && !in_end) byte_position <= byte_position + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    word_buffer <= word_buffer_next;
  end

endmodule

@@ hw/rtl/ctl_queue.sv @@
// Token queue between the front end and the output: takes up to three tokens a cycle.
module ctl_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic [1:0]      push_count,
  input  ctl_pkg::token_t push0,
  input  ctl_pkg::token_t push1,
  input  ctl_pkg::token_t push2,
  output logic            space_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output ctl_pkg::token_t out_tok
);
  import ctl_pkg::*;

  token_t                mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   rd_ptr, wr_ptr;
  logic [QUEUE_AW:0]     count, count_next;
  logic                  pop;

  assign out_valid = count != '0;
  assign out_tok   = mem[rd_ptr];
  assign pop       = out_valid && out_ready;
  // Room for a full burst of three is needed before a word is taken.
  assign space_ok  = count <= (QUEUE_AW + 1)'(QUEUE_DEPTH - 3);
  assign count_next = count + (QUEUE_AW + 1)'(push_count) - (QUEUE_AW + 1)'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      count  <= '0;
    end else begin
      count  <= count_next;
      wr_ptr <= wr_ptr + QUEUE_AW'(push_count);
      if (pop) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push_count > 2'd0) mem[wr_ptr] <= push0;
    if (push_count > 2'd1) mem[wr_ptr + QUEUE_AW'(1)] <= push1;
    if (push_count > 2'd2) mem[wr_ptr + QUEUE_AW'(2)] <= push2;
  end

endmodule

@@ verif/c_token_lexer_test.sv @@
// Self-checking testbench for the C token lexer, driven byte by byte from generated C text.
`timescale 1ns / 100ps

module c_token_lexer_test;
  import ctl_pkg::*;

  typedef enum int {
    LX_IDLE, LX_SYM, LX_BSL, LX_SKIP, LX_BLK1, LX_BLK, LX_CH, LX_CHESC,
    LX_CHEND, LX_NUM, LX_WORD, LX_HASH, LX_DWORD, LX_STR
  } lex_state_e;

  // Token predictor and store of expected tokens.
  class token_scoreboard;
    lex_state_e st;
    logic [7:0]  held_sym;
    logic [7:0]  last_str_byte;
    logic [31:0] offset;
    logic [31:0] tok_start;
    logic [15:0] wlen;
    logic [7:0]  wbuf [MAX_KEYWORD_LENGTH];
    logic [63:0] num_acc;
    bit          stopped;
    token_t      expected_q [$];
    token_t      item_q [$];
    int          fails;
    string kw_names [KW_COUNT] = '{"void", "_Bool", "char", "int", "long", "struct",
      "enum", "if", "else", "switch", "case", "default", "for", "do", "while",
      "break", "continue", "sizeof", {"_Align", "of"}, "typedef", "return", "extern",
      "const", {"_Thread", "_local"}};

    function void push_token(logic [4:0] kind, logic [4:0] kidx, logic [31:0] start,
                             logic [15:0] len, logic [63:0] val);
      token_t t;
      if (item_q.size() >= 3) return;
      t.kind = kind; t.kidx = kidx; t.start = start; t.len = len; t.value = val;
      t.last = 1'b0;
      item_q.push_back(t);
    endfunction

    function void raise_error(logic [31:0] at);
      push_token(K_ERR, 5'd0, at, 16'd1, 64'd0);
      stopped = 1;
      st = LX_IDLE;
    endfunction

    function bit one_of(logic [7:0] c, string s);
      for (int i = 0; i < s.len(); i++) if (s[i] == c) return 1;
      return 0;
    endfunction

    function bit word_char(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") ||
             (c >= "0" && c <= "9") || c == "_";
    endfunction

    function bit word_equals(string s);
      if (wlen != s.len()) return 0;
      for (int i = 0; i < s.len(); i++) if (wbuf[i] != s[i]) return 0;
      return 1;
    endfunction

    function void word_append(logic [7:0] c);
      if (wlen < MAX_KEYWORD_LENGTH) wbuf[wlen] = c;
      if (wlen != 16'hFFFF) wlen++;
    endfunction

    function void close_word(bit with_keywords);
      if (with_keywords) begin
        for (int i = 0; i < KW_COUNT; i++) begin
          if (word_equals(kw_names[i])) begin
            push_token(i < 7 ? K_TYPE : 5'(i - 1), 5'(i), tok_start, wlen, 64'd0);
            return;
          end
        end
      end
      push_token(K_IDENT, 5'd0, tok_start, wlen, 64'd0);
    endfunction

    function void open_word(logic [7:0] c, logic [31:0] at, lex_state_e next);
      tok_start = at;
      wlen = 0;
      word_append(c);
      st = next;
    endfunction

    function void open_string(logic [31:0] at);
      push_token(K_PUNCT, 5'd0, at, 16'd1, 64'd0);
      last_str_byte = "\"";
      st = LX_STR;
    endfunction

    function void hold_backslash(logic [31:0] at);
      tok_start = at;
      held_sym = "\\";
      st = LX_BSL;
    endfunction

    // Start of a fresh token from the idle state.
    function void from_idle(logic [7:0] c, logic [31:0] at);
      st = LX_IDLE;
      if (c == " " || c == "\t" || c == "\n") return;
      if (c == "'") begin st = LX_CH; return; end
      if (c >= "0" && c <= "9") begin
        tok_start = at;
        num_acc = 64'(c - "0");
        st = LX_NUM;
        return;
      end
      if (one_of(c, "<=>!+*-/&|")) begin
        tok_start = at;
        held_sym = c;
        st = LX_SYM;
        return;
      end
      if (one_of(c, "%(),;.[]?:")) begin
        push_token(K_PUNCT, 5'd0, at, 16'd1, 64'd0);
        return;
      end
      if (word_char(c)) begin open_word(c, at, LX_WORD); return; end
      if (c == "#") begin tok_start = at; st = LX_HASH; return; end
      if (c == "{" || c == "}") begin
        push_token(K_BRACE, 5'd0, at, 16'd1, 64'd0);
        return;
      end
      if (c == "\"") begin open_string(at); return; end
      if (c == "\\") begin hold_backslash(at); return; end
      raise_error(at);
    endfunction

    function void take_byte(logic [7:0] b, logic [31:0] at);
      logic [7:0]  c;
      logic [63:0] v;
      logic [63:0] d;
      c = held_sym;
      case (st)
        LX_SYM: begin
          if (c == "/" && b == "/") begin st = LX_SKIP; return; end
          if (c == "/" && b == "*") begin st = LX_BLK1; return; end
          if ((b == "=" && one_of(c, "<=>!+*-/")) || (b == c && one_of(c, "<>&|+-")) ||
              (c == "-" && b == ">")) begin
            push_token(K_PUNCT, 5'd0, tok_start, 16'd2, 64'd0);
            st = LX_IDLE;
            return;
          end
          if (c == "|") begin raise_error(tok_start); return; end
          push_token(K_PUNCT, 5'd0, tok_start, 16'd1, 64'd0);
          from_idle(b, at);
        end
        LX_BSL: begin
          if (b == "\\") begin
            push_token(K_IDENT, 5'd0, tok_start, 16'd1, 64'd0);
            st = LX_IDLE;
          end else raise_error(tok_start);
        end
        LX_SKIP: if (b == "\n") st = LX_IDLE;
        LX_BLK1: begin last_str_byte = b; st = LX_BLK; end
        LX_BLK: begin
          if (last_str_byte == "*" && b == "/") st = LX_IDLE;
          else last_str_byte = b;
        end
        LX_CH: begin
          if (b == "\\") begin st = LX_CHESC; return; end
          push_token(K_NUM, 5'd0, at, 16'd1, {{56{b[7]}}, b});
          st = LX_CHEND;
        end
        LX_CHESC: begin
          case (b)
            "0": v = 64'd0;
            "n": v = 64'd10;
            "t": v = 64'd9;
            "\\": v = 64'd92;
            "'": v = 64'd39;
            default: begin raise_error(at); return; end
          endcase
          push_token(K_NUM, 5'd0, at, 16'd1, v);
          st = LX_CHEND;
        end
        LX_CHEND: begin
          if (b == "'") st = LX_IDLE;
          else raise_error(at);
        end
        LX_NUM: begin
          if (b >= "0" && b <= "9") begin
            d = 64'(b - "0");
            if (num_acc > (VAL_MAX - d) / 64'd10) num_acc = VAL_MAX;
            else num_acc = num_acc * 64'd10 + d;
            return;
          end
          push_token(K_NUM, 5'd0, tok_start, 16'd1, num_acc);
          from_idle(b, at);
        end
        LX_WORD: begin
          if (word_char(b)) begin word_append(b); return; end
          close_word(1);
          from_idle(b, at);
        end
        LX_HASH: begin
          if (word_char(b)) begin open_word(b, at, LX_DWORD); return; end
          st = LX_IDLE;
          if (b == "{" || b == "}") push_token(K_BRACE, 5'd0, at, 16'd1, 64'd0);
          else if (b == "\"") open_string(at);
          else if (b == "\\") hold_backslash(at);
          else raise_error(at);
        end
        LX_DWORD: begin
          if (word_char(b)) begin
            word_append(b);
            if (word_equals("include")) st = LX_SKIP;
            else if (word_equals("define")) begin
              push_token(K_DEFINE, 5'd0, tok_start - 32'd1, 16'd7, 64'd0);
              st = LX_SKIP;
            end
            return;
          end
          close_word(0);
          from_idle(b, at);
        end
        LX_STR: begin
          if (b == "\"" && last_str_byte != "\\") begin
            push_token(K_PUNCT, 5'd0, at, 16'd1, 64'd0);
            st = LX_IDLE;
          end else push_token(K_STRCH, 5'd0, at, 16'd1, 64'd0);
          last_str_byte = b;
        end
        default: from_idle(b, at);
      endcase
    endfunction

    function void take_end(logic [31:0] at);
      case (st)
        LX_SYM: begin
          if (held_sym == "|") begin raise_error(tok_start); return; end
          push_token(K_PUNCT, 5'd0, tok_start, 16'd1, 64'd0);
        end
        LX_BSL: begin raise_error(tok_start); return; end
        LX_NUM: push_token(K_NUM, 5'd0, tok_start, 16'd1, num_acc);
        LX_WORD: close_word(1);
        LX_DWORD: close_word(0);
        LX_IDLE, LX_SKIP: ;
        default: begin raise_error(at); return; end
      endcase
      push_token(K_EOF, 5'd0, at, 16'd1, 64'd0);
      stopped = 1;
      st = LX_IDLE;
    endfunction

    // Note a word accepted at the input and queue the tokens it causes.
    function void note_input(logic [7:0] b, logic eot);
      item_q.delete();
      if (stopped) return;
      if (eot) take_end(offset);
      else begin
        take_byte(b, offset);
        offset++;
      end
      if (item_q.size() > 0) item_q[item_q.size() - 1].last = 1'b1;
      foreach (item_q[i]) expected_q.push_back(item_q[i]);
    endfunction

    // Compare one accepted result word with the oldest expected token.
    function void check_token(token_t got);
      token_t w;
      if (expected_q.size() == 0) begin
        $error("unexpected token kind %0d at offset %0d", got.kind, got.start);
        fails++;
        return;
      end
      w = expected_q.pop_front();
      if (got.kind != w.kind) begin
        $error("token_kind: expected %0d, actual %0d", w.kind, got.kind); fails++;
      end
      if (got.kidx != w.kidx) begin
        $error("keyword_index: expected %0d, actual %0d", w.kidx, got.kidx); fails++;
      end
      if (got.start != w.start) begin
        $error("start_offset: expected %0d, actual %0d", w.start, got.start); fails++;
      end
      if (got.len != w.len) begin
        $error("token_length: expected %0d, actual %0d", w.len, got.len); fails++;
      end
      if (got.value != w.value) begin
        $error("token_value: expected %h, actual %h", w.value, got.value); fails++;
      end
      if (got.last != w.last) begin
        $error("last_result: expected %0d, actual %0d", w.last, got.last); fails++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  ctl_in_if  in_ch ();
  ctl_out_if out_ch ();

  c_token_lexer u_dut (.clk(clk), .rst(rst), .in_ch(in_ch), .out_ch(out_ch));

  always #5 clk = ~clk;

  token_scoreboard sb = new();
  logic [7:0] text_q [$];
  int  words_sent = 0;
  bit  calm = 0;

  initial begin
    #2_000_000;
    $display("c_token_lexer_test failed");
    $finish;
  end

  // Text building helpers.
  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] letter();
    int r;
    r = $urandom_range(52);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    return "_";
  endfunction

  function automatic logic [7:0] printable_except(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(32, 126)); while (c == a || c == b);
    return c;
  endfunction

  // One well-formed construct with random content, then a separator.
  task automatic add_random_construct();
    string puncts [] = '{"+", "-", "*", "/", "%", "&", "(", ")", "<", ">", "=", ",",
      ";", ".", "[", "]", "?", ":", "!", "+=", "-=", "<=", ">=", "==", "!=", "*=",
      "/=", "<<", ">>", "&&", "||", "++", "--", "->", "{", "}"};
    string escs [] = '{"0", "n", "t", "\\", "'"};
    int n;
    logic [7:0] c;
    case ($urandom_range(11))
      0, 1: add_text(puncts[$urandom_range(puncts.size() - 1)]);
      2: begin
        n = $urandom_range(9) == 0 ? $urandom_range(19, 24) : $urandom_range(1, 5);
        repeat (n) text_q.push_back(8'("0" + $urandom_range(9)));
      end
      3: add_text(sb.kw_names[$urandom_range(KW_COUNT - 1)]);
      4: begin
        n = $urandom_range(9) == 0 ? $urandom_range(14, 20) : $urandom_range(1, 6);
        text_q.push_back(letter());
        repeat (n - 1) text_q.push_back($urandom_range(3) == 0 ?
                                        8'("0" + $urandom_range(9)) : letter());
      end
      5: begin
        add_text("'");
        if ($urandom_range(2) == 0) begin
          add_text("\\");
          add_text(escs[$urandom_range(4)]);
        end else begin
          do c = 8'($urandom_range(255)); while (c == "\\");
          text_q.push_back(c);
        end
        add_text("'");
      end
      6: begin
        add_text("\"");
        repeat ($urandom_range(0, 6)) begin
          if ($urandom_range(5) == 0) add_text("\\\"");
          else text_q.push_back(printable_except("\"", "\\"));
        end
        add_text("\"");
      end
      7: begin
        add_text("//");
        repeat ($urandom_range(0, 5)) text_q.push_back(printable_except("\n", "\n"));
        add_text("\n");
      end
      8: begin
        add_text("/*");
        repeat ($urandom_range(0, 6)) text_q.push_back(printable_except("/", "/"));
        add_text("*/");
      end
      9: case ($urandom_range(5))
        0: add_text("#include <x.h>\n");
        1: add_text("#define M 1\n");
        2: add_text("#{");
        3: add_text("#\"q\"");
        4: add_text("#\\\\");
        default: add_text("#inc");
      endcase
      10: add_text("\\\\");
      default: add_text("\t");
    endcase
    case ($urandom_range(2))
      0: add_text(" ");
      1: add_text("\n");
      default: add_text("\t");
    endcase
  endtask

  // Hand over one input word.
  task automatic send_word(logic [7:0] b, logic eot);
    if (!calm && $urandom_range(99) < 37) begin
      in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.text_byte = b;
    in_ch.end_of_text = eot;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_input(b, eot);
    words_sent++;
    @(negedge clk);
  endtask

  // Result side: random back-pressure plus one long hold-off.
  initial begin
    bit held;
    held = 0;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!held && words_sent >= 80) begin
        held = 1;
        out_ch.ready = 1'b0;
        repeat (300) @(negedge clk);
      end
      out_ch.ready = (calm || $urandom_range(99) >= 37);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    token_t got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got.kind = out_ch.token_kind;
      got.kidx = out_ch.keyword_index;
      got.start = out_ch.start_offset;
      got.len = out_ch.token_length;
      got.value = out_ch.token_value;
      got.last = out_ch.last_result;
      sb.check_token(got);
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.text_byte = 8'd0;
    in_ch.end_of_text = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed text: every operator, keyword, literal form and directive.
    add_text("a+=b-=c*=d/=e<=f>=g==h!=i<<j>>k&&l||m++n--o->p%q(r),s;t.u[v]?w:x!y&z|| ");
    add_text("+ - * / < > = & ");
    foreach (sb.kw_names[i]) begin add_text(sb.kw_names[i]); add_text(" "); end
    add_text("averyveryverylongidentifier {} 0 9223372036854775807 99999999999999999999 ");
    add_text("'\\0' '\\n' '\\t' '\\\\' '\\'' 'a' ''' ");
    text_q.push_back("'"); text_q.push_back(8'hFF); text_q.push_back("'");
    text_q.push_back("'"); text_q.push_back(8'h80); text_q.push_back("'");
    add_text(" \"ab\\\"c\" \"\" // note\n/**/ /* a*b */ /*/ x */ ");
    add_text("#include <stdio.h>\n#define N 3\n#{ #\"s\" #\\\\ #int \\\\ #define");
    add_text("\n12abc ");

    // Random constructs until the text is long enough.
    while (text_q.size() < 420) add_random_construct();

    for (int i = 0; i < text_q.size(); i++) begin
      calm = (i >= 150 && i < 250);
      if (i == 300) begin
        in_ch.valid = 1'b0;
        while (sb.expected_q.size() != 0) @(negedge clk);
      end
      send_word(text_q[i], 1'b0);
    end

    // The text ends in one of its terminal cases, picked at random.
    case ($urandom_range(5))
      0: begin send_word("7", 1'b0); send_word(8'h00, 1'b1); end
      1: begin send_word("\"", 1'b0); send_word("s", 1'b0); send_word(8'h00, 1'b1); end
      2: begin send_word("|", 1'b0); send_word("x", 1'b0); end
      3: send_word(8'h0D, 1'b0);
      4: send_word(8'hC3, 1'b0);
      default: begin send_word("/", 1'b0); send_word("/", 1'b0); send_word(8'h00, 1'b1); end
    endcase
    // Words after the halt are ignored by the lexer.
    repeat (10) send_word(8'($urandom_range(255)), 1'($urandom_range(1)));
    in_ch.valid = 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.fails == 0 && sb.expected_q.size() == 0) begin
      $display("c_token_lexer_test passed");
    end else begin
      $display("c_token_lexer_test failed");
    end
    $finish;
  end

endmodule
